// ===== rtl/mcet_pkg.sv =====
package mcet_pkg;

	// Timer table size
	localparam int NUM_TIMERS = 8;
	localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	// Milliseconds added per tick
	localparam logic [31:0] TICK_MS = 32'd10;

	// Reciprocal of ten: (x * RECIP_10) >> RECIP_SHIFT is exactly x / 10 for 32-bit x
	localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	// Operation codes
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SET  = 2'd1;
	localparam logic [1:0] OP_STOP = 2'd2;
	localparam logic [1:0] OP_GET  = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  timer_index;
		logic [31:0] period_ms;
		logic        repeat_mode;
	} mcet_in_t;

	typedef struct packed {
		logic [7:0]  fired_mask;
		logic        event_status;
		logic        index_valid;
		logic [31:0] elapsed_ms;
	} mcet_out_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture the accepted word
		logic step;    // update the table entry under the walk pointer
		logic mul;     // form the period product for set
		logic exec;    // apply set, stop or get to the addressed entry
		logic finish;  // register the result word
	} mcet_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last;    // walk pointer is on the final entry
	} mcet_sts_t;

endpackage

// ===== rtl/mcet_ctrl.sv =====
module mcet_ctrl import mcet_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] operation,
	input  mcet_sts_t  sts,
	output mcet_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_MUL,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	// Decode commands from the current state
	always_comb begin
		cmd        = '0;
		cmd.load   = start && (state_q == S_IDLE);
		cmd.step   = (state_q == S_WALK);
		cmd.mul    = (state_q == S_MUL);
		cmd.exec   = (state_q == S_EXEC);
		cmd.finish = ((state_q == S_WALK) && sts.last) || (state_q == S_EXEC);
	end

	// Sequence the operation and strobe the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (operation)
							OP_TICK: state_q <= S_WALK;
							OP_SET:  state_q <= S_MUL;
							default: state_q <= S_EXEC;
						endcase
					end
				end
				S_WALK: begin
					if (sts.last) state_q <= S_IDLE;
				end
				S_MUL: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ===== rtl/mcet_dp.sv =====
module mcet_dp import mcet_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mcet_in_t  item,
	input  mcet_cmd_t cmd,
	output mcet_sts_t sts,
	output mcet_out_t result
);

	// Timer table
	logic        enabled_q  [NUM_TIMERS];
	logic [31:0] count_q    [NUM_TIMERS];
	logic [31:0] reload_q   [NUM_TIMERS];
	logic        periodic_q [NUM_TIMERS];
	logic        flag_q     [NUM_TIMERS];
	logic [31:0] elapsed_q;

	// Captured word and working registers
	mcet_in_t    item_q;
	logic [IDX_W-1:0] walk_q;
	logic [7:0]  mask_q;
	logic [63:0] prod_q;
	mcet_out_t   result_q;

	logic [IDX_W-1:0] addr;
	logic        idx_ok;
	logic [31:0] dec;
	logic        expire;
	logic [7:0]  hit;
	logic [31:0] period;

	assign idx_ok = (item_q.timer_index < 8'(NUM_TIMERS));
	assign addr   = cmd.step ? walk_q : item_q.timer_index[IDX_W-1:0];
	assign dec    = count_q[addr] - 32'd1;
	assign expire = enabled_q[addr] && (dec == 32'd0);
	assign hit    = expire ? (8'd1 << walk_q) : 8'd0;
	assign period = 32'(prod_q >> RECIP_SHIFT);
	assign sts.last = (walk_q == IDX_W'(NUM_TIMERS - 1));

	// Capture the word, walk the table, apply commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_TIMERS; k++) begin
				enabled_q[k]  <= 1'b0;
				count_q[k]    <= '0;
				reload_q[k]   <= '0;
				periodic_q[k] <= 1'b0;
				flag_q[k]     <= 1'b0;
			end
			elapsed_q <= '0;
			walk_q    <= '0;
			mask_q    <= '0;
		end else begin
			if (cmd.load) begin
				walk_q <= '0;
				mask_q <= '0;
			end
			if (cmd.step) begin
				walk_q <= walk_q + IDX_W'(1);
				mask_q <= mask_q | hit;
				if (enabled_q[addr]) begin
					if (dec == 32'd0) begin
						enabled_q[addr] <= periodic_q[addr];
						count_q[addr]   <= reload_q[addr];
						flag_q[addr]    <= 1'b1;
					end else begin
						count_q[addr] <= dec;
					end
				end
				if (sts.last) elapsed_q <= elapsed_q + TICK_MS;
			end
			if (cmd.exec && idx_ok) begin
				case (item_q.operation)
					OP_SET: begin
						enabled_q[addr]  <= 1'b1;
						count_q[addr]    <= period;
						reload_q[addr]   <= period;
						periodic_q[addr] <= item_q.repeat_mode;
						flag_q[addr]     <= 1'b0;
					end
					OP_STOP: begin
						enabled_q[addr] <= 1'b0;
						flag_q[addr]    <= 1'b0;
					end
					OP_GET: begin
						flag_q[addr] <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Hold the word and the period product
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
		if (cmd.mul) prod_q <= 64'(item_q.period_ms) * 64'(RECIP_10);
	end

	// Register the result word
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (cmd.step) begin
				result_q.fired_mask   <= mask_q | hit;
				result_q.event_status <= 1'b0;
				result_q.index_valid  <= 1'b1;
				result_q.elapsed_ms   <= elapsed_q + TICK_MS;
			end else begin
				result_q.fired_mask   <= 8'd0;
				result_q.event_status <= idx_ok && (item_q.operation == OP_GET) && flag_q[addr];
				result_q.index_valid  <= idx_ok;
				result_q.elapsed_ms   <= elapsed_q;
			end
		end
	end

	assign result = result_q;

endmodule

// ===== rtl/multi_channel_event_timer_top.sv =====
// Tick: busy walking one table entry per cycle; strobed in the cycle after the last entry.
// Set: busy for a reciprocal multiply for ms/10, then the write; stop and get: the write only.
// A new word is taken in the cycle the previous result is strobed; the receiver cannot stall.
// Reset (arst_n low, asynchronous): all timers disabled, counts, periods, flags and the
// millisecond count cleared, controller idle.
module multi_channel_event_timer_top import mcet_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  mcet_in_t  item,
	output logic      busy,
	output logic      done,
	output mcet_out_t result
);

	mcet_cmd_t cmd;
	mcet_sts_t sts;

	mcet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (item.operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	mcet_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

	// Accepting a word makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// Results are never strobed on consecutive cycles
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobed on consecutive cycles");

	// An invalid index never reports fired timers or a flag
	a_invalid_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.index_valid |-> (result.fired_mask == 8'd0) && !result.event_status)
		else $error("invalid index result carries data");

	// Every finished operation is strobed in the next cycle
	a_walk_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> done)
		else $error("finished operation not strobed");

endmodule

// ===== dv/tb_multi_channel_event_timer_top.sv =====
module tb_multi_channel_event_timer_top import mcet_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 1450;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 16;

	// One directed stimulus row, optionally with a hand-written expected word
	typedef struct {
		mcet_in_t  cmd;
		bit        typed;
		mcet_out_t res;
	} stim_row_t;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	mcet_in_t  item   = '0;
	logic      busy;
	logic      done;
	mcet_out_t result;

	// Timer table mirror
	logic        tm_en[NUM_TIMERS];
	logic [31:0] tm_count[NUM_TIMERS];
	logic [31:0] tm_period[NUM_TIMERS];
	logic        tm_periodic[NUM_TIMERS];
	logic        tm_flag[NUM_TIMERS];
	logic [31:0] ms_total;

	mcet_out_t pending_words[$];
	stim_row_t directed_rows[$];
	int        errors = 0;
	int        cycles = 0;
	bit        no_gaps = 1'b0;

	multi_channel_event_timer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d words outstanding", $time, pending_words.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Apply one accepted word to the table mirror and return the word it should produce
	function automatic mcet_out_t apply_word(input mcet_in_t cmd);
		mcet_out_t r;
		int        k;
		int        t;
		r = '0;
		if (cmd.operation == OP_TICK) begin
			r.index_valid = 1'b1;
			for (k = 0; k < NUM_TIMERS; k++) begin
				if (tm_en[k]) begin
					tm_count[k] = tm_count[k] - 32'd1;
					if (tm_count[k] == 32'd0) begin
						if (!tm_periodic[k])
							tm_en[k] = 1'b0;
						tm_count[k] = tm_period[k];
						tm_flag[k]  = 1'b1;
						if (k < 8)
							r.fired_mask[k] = 1'b1;
					end
				end
			end
			ms_total = ms_total + TICK_MS;
		end else if (int'(cmd.timer_index) < NUM_TIMERS) begin
			t = int'(cmd.timer_index);
			r.index_valid = 1'b1;
			case (cmd.operation)
				OP_SET: begin
					tm_en[t]       = 1'b1;
					tm_count[t]    = cmd.period_ms / TICK_MS;
					tm_period[t]   = cmd.period_ms / TICK_MS;
					tm_flag[t]     = 1'b0;
					tm_periodic[t] = cmd.repeat_mode;
				end
				OP_STOP: begin
					tm_en[t]   = 1'b0;
					tm_flag[t] = 1'b0;
				end
				default: begin
					r.event_status = tm_flag[t];
					tm_flag[t]     = 1'b0;
				end
			endcase
		end
		r.elapsed_ms = ms_total;
		return r;
	endfunction

	// Check each strobed word against the oldest expectation
	always @(posedge clk) begin : result_check
		mcet_out_t want;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				$display("%0t unexpected word: expected none, got %h", $time, result);
				errors++;
			end else begin
				want = pending_words.pop_front();
				if (result.fired_mask !== want.fired_mask) begin
					$display("%0t fired_mask: expected %h, got %h", $time,
						want.fired_mask, result.fired_mask);
					errors++;
				end
				if (result.event_status !== want.event_status) begin
					$display("%0t event_status: expected %b, got %b", $time,
						want.event_status, result.event_status);
					errors++;
				end
				if (result.index_valid !== want.index_valid) begin
					$display("%0t index_valid: expected %b, got %b", $time,
						want.index_valid, result.index_valid);
					errors++;
				end
				if (result.elapsed_ms !== want.elapsed_ms) begin
					$display("%0t elapsed_ms: expected %h, got %h", $time,
						want.elapsed_ms, result.elapsed_ms);
					errors++;
				end
			end
		end
	end

	// Present a word, hold it until taken, then log what it should produce
	task automatic send_word(input mcet_in_t cmd, input bit typed, input mcet_out_t res);
		mcet_out_t p;
		start <= 1'b1;
		item  <= cmd;
		do @(posedge clk); while (busy);
		p = apply_word(cmd);
		pending_words.push_back(typed ? res : p);
	endtask

	// Drop start for a random stretch: mostly none or short, a few long
	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			n = 0;
		else if (r < 92)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(8, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic add_row(input logic [1:0] op, input logic [7:0] idx, input logic [31:0] ms,
			input logic rep, input bit typed, input logic [7:0] fired, input logic status,
			input logic valid, input logic [31:0] elapsed);
		stim_row_t row;
		row.cmd.operation      = op;
		row.cmd.timer_index    = idx;
		row.cmd.period_ms      = ms;
		row.cmd.repeat_mode    = rep;
		row.typed              = typed;
		row.res.fired_mask     = fired;
		row.res.event_status   = status;
		row.res.index_valid    = valid;
		row.res.elapsed_ms     = elapsed;
		directed_rows.push_back(row);
	endtask

	// Random word: mostly in-range timers and short periods so timers fire often
	function automatic mcet_in_t random_word();
		mcet_in_t cmd;
		int       r;
		r = $urandom_range(0, 99);
		if (r < 40)
			cmd.operation = OP_TICK;
		else if (r < 65)
			cmd.operation = OP_SET;
		else if (r < 75)
			cmd.operation = OP_STOP;
		else
			cmd.operation = OP_GET;
		r = $urandom_range(0, 9);
		if (r < 8)
			cmd.timer_index = 8'($urandom_range(0, NUM_TIMERS - 1));
		else if (r == 8)
			cmd.timer_index = 8'($urandom_range(NUM_TIMERS, 255));
		else
			cmd.timer_index = 8'($urandom_range(0, 255));
		r = $urandom_range(0, 9);
		if (r < 7)
			cmd.period_ms = $urandom_range(0, 60);
		else if (r < 9)
			cmd.period_ms = $urandom_range(0, 400);
		else
			cmd.period_ms = $urandom();
		cmd.repeat_mode = 1'($urandom_range(0, 1));
		return cmd;
	endfunction

	initial begin : stimulus
		int       i;
		mcet_in_t cmd;
		for (i = 0; i < NUM_TIMERS; i++) begin
			tm_en[i]       = 1'b0;
			tm_count[i]    = '0;
			tm_period[i]   = '0;
			tm_periodic[i] = 1'b0;
			tm_flag[i]     = 1'b0;
		end
		ms_total = '0;

		// Directed rows: reads after reset, out-of-range indexes, extremes, expiry
		add_row(OP_GET,  8'd0,   32'd0,          1'b0, 1, 8'h00, 1'b0, 1'b1, 32'd0);
		add_row(OP_GET,  8'd255, 32'hFFFF_FFFF,  1'b1, 1, 8'h00, 1'b0, 1'b0, 32'd0);
		add_row(OP_SET,  8'd8,   32'd100,        1'b1, 1, 8'h00, 1'b0, 1'b0, 32'd0);
		add_row(OP_STOP, 8'd200, 32'd0,          1'b0, 1, 8'h00, 1'b0, 1'b0, 32'd0);
		add_row(OP_TICK, 8'd255, 32'hFFFF_FFFF,  1'b1, 1, 8'h00, 1'b0, 1'b1, 32'd10);
		add_row(OP_SET,  8'd0,   32'd10,         1'b0, 1, 8'h00, 1'b0, 1'b1, 32'd10);
		add_row(OP_SET,  8'd7,   32'd25,         1'b1, 1, 8'h00, 1'b0, 1'b1, 32'd10);
		// Period below one tick: counter wraps instead of firing
		add_row(OP_SET,  8'd3,   32'd9,          1'b1, 1, 8'h00, 1'b0, 1'b1, 32'd10);
		add_row(OP_SET,  8'd5,   32'hFFFF_FFFF,  1'b1, 1, 8'h00, 1'b0, 1'b1, 32'd10);
		add_row(OP_TICK, 8'd0,   32'd0,          1'b0, 1, 8'h01, 1'b0, 1'b1, 32'd20);
		add_row(OP_TICK, 8'd0,   32'd0,          1'b0, 1, 8'h80, 1'b0, 1'b1, 32'd30);
		add_row(OP_GET,  8'd0,   32'd0,          1'b0, 1, 8'h00, 1'b1, 1'b1, 32'd30);
		add_row(OP_GET,  8'd0,   32'd0,          1'b0, 1, 8'h00, 1'b0, 1'b1, 32'd30);
		add_row(OP_GET,  8'd7,   32'd0,          1'b0, 0, 8'h00, 1'b0, 1'b0, 32'd0);
		add_row(OP_TICK, 8'd0,   32'd0,          1'b0, 0, 8'h00, 1'b0, 1'b0, 32'd0);
		add_row(OP_TICK, 8'd0,   32'd0,          1'b0, 0, 8'h00, 1'b0, 1'b0, 32'd0);
		// Stop clears the flag of a fired periodic timer
		add_row(OP_STOP, 8'd7,   32'd0,          1'b0, 0, 8'h00, 1'b0, 1'b0, 32'd0);
		add_row(OP_GET,  8'd7,   32'd0,          1'b0, 1, 8'h00, 1'b0, 1'b1, 32'd50);
		add_row(OP_TICK, 8'd0,   32'd0,          1'b0, 0, 8'h00, 1'b0, 1'b0, 32'd0);
		add_row(OP_SET,  8'd1,   32'd10,         1'b1, 0, 8'h00, 1'b0, 1'b0, 32'd0);
		add_row(OP_TICK, 8'd0,   32'd0,          1'b0, 0, 8'h00, 1'b0, 1'b0, 32'd0);
		// Re-arming clears a pending flag
		add_row(OP_SET,  8'd1,   32'd19,         1'b0, 0, 8'h00, 1'b0, 1'b0, 32'd0);
		add_row(OP_GET,  8'd1,   32'd0,          1'b0, 1, 8'h00, 1'b0, 1'b1, 32'd70);
		add_row(OP_GET,  8'd5,   32'd0,          1'b0, 0, 8'h00, 1'b0, 1'b0, 32'd0);

		// Hold reset, then release on a clock edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < directed_rows.size(); i++) begin
			send_word(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);
			idle_gap();
		end

		// Random words, mixing gap-free stretches with idling ones
		for (i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 100 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			cmd = random_word();
			send_word(cmd, 1'b0, '0);
			if (i == RANDOM_WORDS / 2 || i == RANDOM_WORDS - 1) begin
				// Drain everything outstanding before going on
				start <= 1'b0;
				while (pending_words.size() != 0) @(posedge clk);
			end else begin
				idle_gap();
			end
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_words.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
